// ===== src/pjq_pkg.sv =====
package pjq_pkg;

	localparam logic KIND_ADD      = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	localparam logic [1:0] STATUS_ADDED      = 2'd0;
	localparam logic [1:0] STATUS_FULL       = 2'd1;
	localparam logic [1:0] STATUS_DISPATCHED = 2'd2;
	localparam logic [1:0] STATUS_NONE       = 2'd3;

	localparam int JOB_W   = 16;
	localparam int PRIO_W  = 16;
	localparam int STAMP_W = 32;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic [JOB_W-1:0]   job;
		logic [PRIO_W-1:0]  prio;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [JOB_W-1:0]   job;
		logic [PRIO_W-1:0]  prio;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

// ===== src/pjq_mem.sv =====
module pjq_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  pjq_pkg::entry_t     wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output pjq_pkg::entry_t     rdata
);

	pjq_pkg::entry_t ram_q [DEPTH];
	pjq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= ram_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pjq_ctrl.sv =====
module pjq_ctrl #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [pjq_pkg::JOB_W-1:0]     job_id,
	input  logic [pjq_pkg::PRIO_W-1:0]    priority_req,
	input  logic [pjq_pkg::STAMP_W-1:0]   frame_stamp,
	output logic                          res_valid,
	output pjq_pkg::res_t                 res,
	input  logic                          res_take
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_MOVE  = 2'd3;

	logic [1:0]       state_q;
	logic [CW-1:0]    count_q;
	logic             en_q;
	logic [AW-1:0]    scan_idx_q;
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	pjq_pkg::entry_t  best_q;
	logic [AW-1:0]    best_idx_q;
	pjq_pkg::entry_t  last_q;
	pjq_pkg::res_t    res_q;
	logic             res_pend_q;

	logic             accept;
	logic             full;
	logic [AW-1:0]    last_idx;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	pjq_pkg::entry_t  mem_wdata;
	logic             mem_re;
	pjq_pkg::entry_t  mem_rdata;
	pjq_pkg::entry_t  in_entry;
	logic             take_cand;
	logic [CW-1:0]    count_inc;
	logic [CW-1:0]    count_dec;
	logic [CW+pjq_pkg::COUNT_W-1:0] inc_ext;
	logic [CW+pjq_pkg::COUNT_W-1:0] dec_ext;
	logic [CW+pjq_pkg::COUNT_W-1:0] cur_ext;

	assign in_stall  = (state_q != S_IDLE) || res_pend_q;
	assign accept    = in_valid && !in_stall;
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign last_idx  = AW'(count_q - CW'(1));
	assign count_inc = count_q + CW'(1);
	assign count_dec = count_q - CW'(1);
	assign inc_ext   = (CW+pjq_pkg::COUNT_W)'(count_inc);
	assign dec_ext   = (CW+pjq_pkg::COUNT_W)'(count_dec);
	assign cur_ext   = (CW+pjq_pkg::COUNT_W)'(count_q);

	assign in_entry.job   = job_id;
	assign in_entry.prio  = priority_req;
	assign in_entry.stamp = frame_stamp;

	// Slots are only written by an add or the final move, never during a scan,
	// so reads and writes of one entry cannot overlap.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(count_q);
		mem_wdata = in_entry;
		if (state_q == S_MOVE) begin
			mem_we    = 1'b1;
			mem_waddr = best_idx_q;
			mem_wdata = last_q;
		end else if (accept && kind == pjq_pkg::KIND_ADD && !full) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re = (state_q == S_SCAN);

	pjq_mem #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (scan_idx_q),
		.rdata (mem_rdata)
	);

	// Earlier slot wins an exact tie, so only a strictly better entry replaces.
	assign take_cand = (idx_s1 == '0) ||
		(mem_rdata.prio < best_q.prio) ||
		((mem_rdata.prio == best_q.prio) && (mem_rdata.stamp < best_q.stamp));

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			last_q <= mem_rdata;
			if (take_cand) begin
				best_q     <= mem_rdata;
				best_idx_q <= idx_s1;
			end
		end
		idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			en_q       <= 1'b0;
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			res_pend_q <= 1'b0;
			res_q      <= '0;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (res_take) begin
				res_pend_q <= 1'b0;
			end
			vld_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q.job  <= '0;
						res_q.prio <= '0;
						if (kind == pjq_pkg::KIND_ADD) begin
							res_pend_q <= 1'b1;
							if (full) begin
								res_q.status <= pjq_pkg::STATUS_FULL;
								res_q.count  <= cur_ext[pjq_pkg::COUNT_W-1:0];
							end else begin
								count_q      <= count_inc;
								res_q.status <= pjq_pkg::STATUS_ADDED;
								res_q.count  <= inc_ext[pjq_pkg::COUNT_W-1:0];
							end
						end else if (!en_q || count_q == '0) begin
							res_pend_q   <= 1'b1;
							res_q.status <= pjq_pkg::STATUS_NONE;
							res_q.count  <= cur_ext[pjq_pkg::COUNT_W-1:0];
						end else begin
							scan_idx_q <= '0;
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_idx_q == last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					// Refill the freed slot from the last one and shrink the table.
					count_q      <= count_dec;
					res_pend_q   <= 1'b1;
					res_q.status <= pjq_pkg::STATUS_DISPATCHED;
					res_q.job    <= best_q.job;
					res_q.prio   <= best_q.prio;
					res_q.count  <= dec_ext[pjq_pkg::COUNT_W-1:0];
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_pend_q;
	assign res       = res_q;

endmodule

// ===== src/priority_job_queue.sv =====
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  kind, job_id, priority_req, frame_stamp
// out      output     out_valid/out_stall status, out_job_id, out_priority, job_count
// cfg      input      cfg_we             cfg_wdata (dispatch enable)
//
// An add, a rejected add, or an empty or disabled dispatch is answered without a scan.
// A dispatch holds the input while it scans the queued slots, one slot read a cycle through
// the single read port, and then passes through a drain and a move state.
// Reset clears the count and the enable; slot contents need no clearing.
// A result waits in the output register while out_stall is high; the next
// transaction is still taken and its result held back until the register frees.
module priority_job_queue #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [pjq_pkg::JOB_W-1:0]   job_id,
	input  logic [pjq_pkg::PRIO_W-1:0]  priority_req,
	input  logic [pjq_pkg::STAMP_W-1:0] frame_stamp,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [pjq_pkg::JOB_W-1:0]   out_job_id,
	output logic [pjq_pkg::PRIO_W-1:0]  out_priority,
	output logic [pjq_pkg::COUNT_W-1:0] job_count
);

	logic          res_valid;
	pjq_pkg::res_t res;
	logic          res_take;
	logic          out_valid_q;
	pjq_pkg::res_t out_res_q;

	pjq_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.job_id       (job_id),
		.priority_req (priority_req),
		.frame_stamp  (frame_stamp),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take)
	);

	// Load when the register is empty or its transaction leaves this edge.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_res_q.status;
	assign out_job_id   = out_res_q.job;
	assign out_priority = out_res_q.prio;
	assign job_count    = out_res_q.count;

endmodule

// ===== src/pjq_checker.sv =====
module pjq_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  status,
	input logic [pjq_pkg::JOB_W-1:0]   out_job_id,
	input logic [pjq_pkg::PRIO_W-1:0]  out_priority,
	input logic [pjq_pkg::COUNT_W-1:0] job_count
);

	localparam int CX = (TABLE_DEPTH > 127) ? TABLE_DEPTH + 1 : 128;
	localparam logic [$clog2(CX)-1:0] DEPTH_X = $clog2(CX)'(TABLE_DEPTH);

	// Hold the result while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(status) && $stable(out_job_id) &&
			$stable(out_priority) && $stable(job_count))
		else $error("result changed under stall");

	// One transaction at a time: input stalls right after a transaction.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous transaction in flight");

	// Non-dispatch results carry no job.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == pjq_pkg::STATUS_ADDED || status == pjq_pkg::STATUS_FULL ||
			status == pjq_pkg::STATUS_NONE) |->
			out_job_id == '0 && out_priority == '0)
		else $error("job fields set on a non-dispatch result");

	// A rejected add reports a full table.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pjq_pkg::STATUS_FULL |->
			job_count == DEPTH_X[pjq_pkg::COUNT_W-1:0])
		else $error("add rejected below full");

endmodule

bind priority_job_queue pjq_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_pjq_checker (.*);
